// ===== rtl/core/sli_pkg.sv =====
package sli_pkg;

    localparam int unsigned LINK_W  = 7;
    localparam int unsigned VALUE_W = 32;

    // all-ones link code marks the end of a chain
    localparam logic [LINK_W-1:0] NULL_LINK = {LINK_W{1'b1}};

    localparam logic FUNC_INSERT  = 1'b0;
    localparam logic FUNC_READOUT = 1'b1;

    localparam logic [1:0] STAT_INSERTED = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_ELEMENT  = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE,
        S_CMP,
        S_LINK,
        S_LINK_PREV,
        S_DONE,
        S_READ
    } t_state;

    // one access bundle toward the node store
    typedef struct packed {
        logic               rd_en;
        logic [LINK_W-1:0]  rd_addr;
        logic               val_we;
        logic [LINK_W-1:0]  val_addr;
        logic [VALUE_W-1:0] val_data;
        logic               link_we;
        logic [LINK_W-1:0]  link_addr;
        logic [LINK_W-1:0]  link_data;
    } t_store_cmd;

endpackage

// ===== rtl/core/sli_node_store.sv =====
module sli_node_store #(
    parameter int NODE_COUNT = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sli_pkg::t_store_cmd           i_cmd,
    output logic [sli_pkg::VALUE_W-1:0]   o_value,
    output logic [sli_pkg::LINK_W-1:0]    o_link
);

    localparam int IDX_W = $clog2(NODE_COUNT);

    logic [sli_pkg::VALUE_W-1:0] r_value_mem [NODE_COUNT];
    logic [sli_pkg::LINK_W-1:0]  r_link_mem  [NODE_COUNT];
    logic [NODE_COUNT-1:0]       r_link_set;
    logic [sli_pkg::VALUE_W-1:0] r_value_q;
    logic [sli_pkg::LINK_W-1:0]  r_link_q;

    logic [IDX_W-1:0]            w_rd_idx;
    logic [IDX_W-1:0]            w_val_idx;
    logic [IDX_W-1:0]            w_link_idx;
    logic [sli_pkg::LINK_W-1:0]  w_link_init;

    assign w_rd_idx   = i_cmd.rd_addr[IDX_W-1:0];
    assign w_val_idx  = i_cmd.val_addr[IDX_W-1:0];
    assign w_link_idx = i_cmd.link_addr[IDX_W-1:0];

    // untouched entry chains to its successor, the last one ends the free list
    assign w_link_init = (w_rd_idx == IDX_W'(NODE_COUNT - 1)) ? sli_pkg::NULL_LINK
                       : sli_pkg::LINK_W'(w_rd_idx) + sli_pkg::LINK_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.val_we) begin
            r_value_mem[w_val_idx] <= i_cmd.val_data;
        end
        if (i_cmd.rd_en) begin
            r_value_q <= r_value_mem[w_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.link_we) begin
            r_link_mem[w_link_idx] <= i_cmd.link_data;
        end
        if (i_cmd.rd_en) begin
            r_link_q <= r_link_set[w_rd_idx] ? r_link_mem[w_rd_idx] : w_link_init;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_set <= '0;
        end else if (i_cmd.link_we) begin
            r_link_set[w_link_idx] <= 1'b1;
        end
    end

    assign o_value = r_value_q;
    assign o_link  = r_link_q;

endmodule

// ===== rtl/core/sorted_list_insert_free_list.sv =====
// Insert: takes the free-list head node, then walks the list with one compare per cycle on the
// node store's registered read port; an empty list skips the walk and a full list skips the store.
// Readout: one element per cycle while the consumer is ready.
// One request at a time; the next is taken once the last result is in the output register.
// Reset (synchronous, active low) empties the list and frees every node at once;
// no clearing pass is needed.
module sorted_list_insert_free_list #(
    parameter int NODE_COUNT = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_func,
    input  logic signed [31:0]  i_value_in,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_status,
    output logic signed [31:0]  o_value_out,
    output logic                o_last
);

    localparam int LW = sli_pkg::LINK_W;

    sli_pkg::t_state     r_state, n_state;
    logic [31:0]         r_data, n_data;
    logic [LW-1:0]       r_node, n_node;
    logic [LW-1:0]       r_prev, n_prev;
    logic [LW-1:0]       r_cur, n_cur;
    logic [LW-1:0]       r_list_head, n_list_head;
    logic [LW-1:0]       r_free_head, n_free_head;
    logic [1:0]          r_status, n_status;

    logic                r_o_valid;
    logic [1:0]          r_o_status;
    logic [31:0]         r_o_value;
    logic                r_o_last;

    logic                w_out_free;
    logic                w_out_load;
    logic [1:0]          w_out_status;
    logic [31:0]         w_out_value;
    logic                w_out_last;

    sli_pkg::t_store_cmd w_cmd;
    logic [31:0]         w_value;
    logic [LW-1:0]       w_link;

    function automatic logic link_ok(input logic [LW-1:0] l);
        return l < LW'(NODE_COUNT);
    endfunction

    sli_node_store #(
        .NODE_COUNT (NODE_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_value (w_value),
        .o_link  (w_link)
    );

    assign w_out_free = !r_o_valid || i_ready;

    always_comb begin
        n_state      = r_state;
        n_data       = r_data;
        n_node       = r_node;
        n_prev       = r_prev;
        n_cur        = r_cur;
        n_list_head  = r_list_head;
        n_free_head  = r_free_head;
        n_status     = r_status;
        w_cmd        = '0;
        w_out_load   = 1'b0;
        w_out_status = r_status;
        w_out_value  = '0;
        w_out_last   = 1'b1;
        o_ready      = (r_state == sli_pkg::S_IDLE);

        unique case (r_state)
            sli_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_data = i_value_in;
                    if (i_func == sli_pkg::FUNC_INSERT) begin
                        if (!link_ok(r_free_head)) begin
                            n_status = sli_pkg::STAT_FULL;
                            n_state  = sli_pkg::S_DONE;
                        end else begin
                            n_node         = r_free_head;
                            n_cur          = r_list_head;
                            n_prev         = sli_pkg::NULL_LINK;
                            w_cmd.val_we   = 1'b1;
                            w_cmd.val_addr = r_free_head;
                            w_cmd.val_data = i_value_in;
                            w_cmd.rd_en    = 1'b1;
                            w_cmd.rd_addr  = r_free_head;
                            n_state        = sli_pkg::S_FREE;
                        end
                    end else begin
                        if (!link_ok(r_list_head)) begin
                            n_status = sli_pkg::STAT_EMPTY;
                            n_state  = sli_pkg::S_DONE;
                        end else begin
                            w_cmd.rd_en   = 1'b1;
                            w_cmd.rd_addr = r_list_head;
                            n_state       = sli_pkg::S_READ;
                        end
                    end
                end
            end
            sli_pkg::S_FREE: begin
                // pop the taken node off the free list, then start the walk
                n_free_head = w_link;
                if (link_ok(r_cur)) begin
                    w_cmd.rd_en   = 1'b1;
                    w_cmd.rd_addr = r_cur;
                    n_state       = sli_pkg::S_CMP;
                end else begin
                    n_state = sli_pkg::S_LINK;
                end
            end
            sli_pkg::S_CMP: begin
                if ($signed(w_value) < $signed(r_data)) begin
                    n_prev = r_cur;
                    n_cur  = w_link;
                    if (link_ok(w_link)) begin
                        w_cmd.rd_en   = 1'b1;
                        w_cmd.rd_addr = w_link;
                    end else begin
                        n_state = sli_pkg::S_LINK;
                    end
                end else begin
                    n_state = sli_pkg::S_LINK;
                end
            end
            sli_pkg::S_LINK: begin
                w_cmd.link_we   = 1'b1;
                w_cmd.link_addr = r_node;
                w_cmd.link_data = link_ok(r_cur) ? r_cur : sli_pkg::NULL_LINK;
                n_status        = sli_pkg::STAT_INSERTED;
                if (link_ok(r_prev)) begin
                    n_state = sli_pkg::S_LINK_PREV;
                end else begin
                    n_list_head = r_node;
                    n_state     = sli_pkg::S_DONE;
                end
            end
            sli_pkg::S_LINK_PREV: begin
                w_cmd.link_we   = 1'b1;
                w_cmd.link_addr = r_prev;
                w_cmd.link_data = r_node;
                n_state         = sli_pkg::S_DONE;
            end
            sli_pkg::S_DONE: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = sli_pkg::S_IDLE;
                end
            end
            sli_pkg::S_READ: begin
                // hold the fetched node until the output register frees up
                if (w_out_free) begin
                    w_out_load   = 1'b1;
                    w_out_status = sli_pkg::STAT_ELEMENT;
                    w_out_value  = w_value;
                    w_out_last   = !link_ok(w_link);
                    if (link_ok(w_link)) begin
                        w_cmd.rd_en   = 1'b1;
                        w_cmd.rd_addr = w_link;
                    end else begin
                        n_state = sli_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = sli_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sli_pkg::S_IDLE;
            r_list_head <= sli_pkg::NULL_LINK;
            r_free_head <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_list_head <= n_list_head;
            r_free_head <= n_free_head;
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data   <= n_data;
        r_node   <= n_node;
        r_prev   <= n_prev;
        r_cur    <= n_cur;
        r_status <= n_status;
        if (w_out_load) begin
            r_o_status <= w_out_status;
            r_o_value  <= w_out_value;
            r_o_last   <= w_out_last;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_status    = r_o_status;
    assign o_value_out = r_o_value;
    assign o_last      = r_o_last;

    a_status_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != sli_pkg::STAT_ELEMENT)) |-> (o_last && (o_value_out == 0)))
        else $error("non-element result must be final and carry zero");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state != sli_pkg::S_IDLE))
        else $error("accepted request did not start work");

    a_cmp_node_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sli_pkg::S_CMP) |-> link_ok(r_cur))
        else $error("walk compares against a null node");

    a_link_node_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sli_pkg::S_LINK || r_state == sli_pkg::S_LINK_PREV) |-> link_ok(r_node))
        else $error("linking a node outside the store");

endmodule
